@@ src/fpcc_pkg.sv @@
// Shared types, constants and functions for the FIFO page cache controller.
// No dependencies; used by fpcc_div and fifo_page_cache_controller_unit.
package fpcc_pkg;

	localparam int IDX_W     = 32;  // element index / page number width
	localparam int PS_W      = 17;  // page size register width
	localparam int OFF_W     = 16;  // offset width
	localparam int CNT_W     = 17;  // element count width
	localparam int TOT_W     = 32;  // total_elements width
	localparam int PROD_W    = IDX_W + PS_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int DIV_CNT_W = 5;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(IDX_W - 1);

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = CFG_IDX_W'(1);

	localparam logic [PS_W-1:0] PS_RESET = PS_W'(256);
	localparam logic [PS_W-1:0] PS_MAX   = PS_W'(65536);

	// divider result, handed back to the sequencer
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] quot;
		logic [OFF_W-1:0] rem;
	} div_res_t;

	// elements in the page starting at start: full, shortened at the end, or none
	function automatic logic [CNT_W-1:0] page_len(
		input logic [PROD_W-1:0] start,
		input logic [PS_W-1:0]   ps,
		input logic [TOT_W-1:0]  total
	);
		logic [PROD_W:0]   end_v;
		logic [PROD_W:0]   tot_v;
		logic [PROD_W-1:0] diff;
		logic [CNT_W-1:0]  len;
		tot_v = (PROD_W+1)'(total);
		end_v = {1'b0, start} + (PROD_W+1)'(ps);
		diff  = PROD_W'(total) - start;
		if ({1'b0, start} >= tot_v) begin
			len = '0;
		end else if (end_v > tot_v) begin
			len = diff[CNT_W-1:0];
		end else begin
			len = ps;
		end
		return len;
	endfunction

endpackage

@@ src/fpcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/fpcc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the index / page size split.
// Depends on fpcc_pkg.
module fpcc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fpcc_pkg::IDX_W-1:0]    dividend,
	input  logic [fpcc_pkg::PS_W-1:0]     divisor,
	output fpcc_pkg::div_res_t            res
);

	logic [fpcc_pkg::IDX_W-1:0]     quo_q;
	logic [fpcc_pkg::PS_W-1:0]      rem_q;
	logic [fpcc_pkg::PS_W-1:0]      dvs_q;
	logic [fpcc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [fpcc_pkg::PS_W:0]        shifted;
	logic [fpcc_pkg::PS_W:0]        diff;
	logic                           ge;

	assign shifted = {rem_q, quo_q[fpcc_pkg::IDX_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fpcc_pkg::DIV_LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[fpcc_pkg::IDX_W-2:0], ge};
			rem_q <= ge ? diff[fpcc_pkg::PS_W-1:0] : shifted[fpcc_pkg::PS_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q[fpcc_pkg::OFF_W-1:0];

endmodule

@@ src/fifo_page_cache_controller_unit.sv @@
// FIFO page cache controller, top level: sequencer, slot state and result register.
// Depends on fpcc_pkg, fpcc_div and fpcc_ram.
//
// One item (an element index) is taken while the block is idle; the block then
// holds in_stall high until the result is placed in the output register. The
// index is split into page number and offset by a one-bit-per-cycle divider
// (32 steps), then the SLOTS page tags are read from a small RAM one per
// cycle, lowest slot first, until the page is found or every slot is ruled
// out. A miss reads the victim tag, writes the new one, and forms the
// write-back and load lengths through one 32x17 multiplier and a compare
// against total_elements. Replacement is round robin over the slots, which
// is FIFO order. Every access marks its slot dirty; hit and fault totals
// saturate. A finished item waits in the output register while the next
// item is already being worked on.
// Configuration writes are always ready (cfg_ready high); index 0 is
// page_size (0 acts as 1, above 65536 acts as 65536), index 1 is
// total_elements, other indexes are ignored.
module fifo_page_cache_controller_unit #(
	parameter int SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpcc_pkg::CFG_DAT_W-1:0]    cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fpcc_pkg::IDX_W-1:0]        element_index,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [5:0]                        slot,
	output logic [fpcc_pkg::OFF_W-1:0]        offset,
	output logic [fpcc_pkg::IDX_W-1:0]        page_number,
	output logic                              writeback_needed,
	output logic [fpcc_pkg::IDX_W-1:0]        writeback_page,
	output logic [fpcc_pkg::CNT_W-1:0]        writeback_count,
	output logic [fpcc_pkg::CNT_W-1:0]        load_count,
	output logic [31:0]                       fault_count,
	output logic [31:0]                       hit_count
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIV  = 8'b0000_0010,
		ST_SCAN = 8'b0000_0100,
		ST_VRD  = 8'b0000_1000,
		ST_WB   = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_LEN  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [fpcc_pkg::PS_W-1:0]  page_size_q;
	logic [fpcc_pkg::TOT_W-1:0] total_q;

	// working registers of the current item
	logic [fpcc_pkg::IDX_W-1:0]  idx_q;
	logic [fpcc_pkg::PS_W-1:0]   ps_q;
	logic [fpcc_pkg::IDX_W-1:0]  page_q;
	logic [fpcc_pkg::OFF_W-1:0]  off_q;
	logic                        hit_w_q;
	logic [SW-1:0]               sel_q;
	logic                        wb_need_q;
	logic [fpcc_pkg::IDX_W-1:0]  wb_page_q;
	logic [fpcc_pkg::CNT_W-1:0]  wb_cnt_q;
	logic [fpcc_pkg::CNT_W-1:0]  load_q;
	logic [fpcc_pkg::PROD_W-1:0] prod_q;

	// tag scan
	logic [SW-1:0] issue_q;
	logic          issue_done_q;
	logic [SW-1:0] cmp_addr_q;
	logic          cmp_vld_q;

	// slot state
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] dirty_q;
	logic [SW-1:0]    vp_q;
	logic [31:0]      faults_q;
	logic [31:0]      hits_q;

	// output register
	logic                        out_valid_q;
	logic                        o_hit_q;
	logic [5:0]                  o_slot_q;
	logic [fpcc_pkg::OFF_W-1:0]  o_off_q;
	logic [fpcc_pkg::IDX_W-1:0]  o_page_q;
	logic                        o_wb_need_q;
	logic [fpcc_pkg::IDX_W-1:0]  o_wb_page_q;
	logic [fpcc_pkg::CNT_W-1:0]  o_wb_cnt_q;
	logic [fpcc_pkg::CNT_W-1:0]  o_load_q;

	logic                        accept;
	logic                        emit;
	logic [fpcc_pkg::PS_W-1:0]   eff_ps;
	fpcc_pkg::div_res_t          div_res;
	logic [SW-1:0]               raddr;
	logic [fpcc_pkg::IDX_W-1:0]  rdata;
	logic                        ram_we;
	logic                        tag_match;
	logic [fpcc_pkg::PROD_W-1:0] prod_d;
	logic [fpcc_pkg::PROD_W-1:0] load_start;
	logic [31:0]                 faults_nx;
	logic [31:0]                 hits_nx;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	// result moves into the output register once that register is free
	assign emit      = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		if (page_size_q == '0) begin
			eff_ps = fpcc_pkg::PS_W'(1);
		end else if (page_size_q > fpcc_pkg::PS_MAX) begin
			eff_ps = fpcc_pkg::PS_MAX;
		end else begin
			eff_ps = page_size_q;
		end
	end

	fpcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (element_index),
		.divisor  (eff_ps),
		.res      (div_res)
	);

	// page tags; a tag is only compared where its valid bit is set
	assign raddr  = (state_q == ST_VRD) ? vp_q : issue_q;
	assign ram_we = (state_q == ST_WB);

	fpcc_ram #(
		.WIDTH (fpcc_pkg::IDX_W),
		.DEPTH (SLOTS)
	) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vp_q),
		.wdata (page_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign tag_match  = cmp_vld_q && valid_q[cmp_addr_q] && (rdata == page_q);
	assign prod_d     = fpcc_pkg::PROD_W'(wb_page_q) * fpcc_pkg::PROD_W'(ps_q);
	assign load_start = fpcc_pkg::PROD_W'(idx_q - fpcc_pkg::IDX_W'(off_q));

	assign faults_nx = (!hit_w_q && faults_q != '1) ? faults_q + 32'd1 : faults_q;
	assign hits_nx   = ( hit_w_q && hits_q   != '1) ? hits_q   + 32'd1 : hits_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= fpcc_pkg::PS_RESET;
			total_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpcc_pkg::REG_PAGE_SIZE: page_size_q <= cfg_data[fpcc_pkg::PS_W-1:0];
				fpcc_pkg::REG_TOTAL:     total_q     <= cfg_data[fpcc_pkg::TOT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_done_q <= 1'b0;
			cmp_vld_q    <= 1'b0;
			valid_q      <= '0;
			dirty_q      <= '0;
			vp_q         <= '0;
			faults_q     <= '0;
			hits_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q      <= ST_SCAN;
						issue_done_q <= 1'b0;
						cmp_vld_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= !issue_done_q;
					if (!issue_done_q && issue_q == LAST_SLOT) begin
						issue_done_q <= 1'b1;
					end
					if (tag_match) begin
						state_q <= ST_FIN;
					end else if (issue_done_q && !cmp_vld_q) begin
						state_q <= ST_VRD;
					end
				end
				ST_VRD: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					valid_q[vp_q] <= 1'b1;
					vp_q          <= (vp_q == LAST_SLOT) ? '0 : vp_q + 1'b1;
					state_q       <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (emit) begin
						dirty_q[sel_q] <= 1'b1;
						faults_q       <= faults_nx;
						hits_q         <= hits_nx;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= element_index;
			ps_q  <= eff_ps;
		end
		if (state_q == ST_DIV && div_res.done) begin
			page_q  <= div_res.quot;
			off_q   <= div_res.rem;
			issue_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (!issue_done_q) begin
				cmp_addr_q <= issue_q;
				if (issue_q != LAST_SLOT) begin
					issue_q <= issue_q + 1'b1;
				end
			end
			if (tag_match) begin
				hit_w_q   <= 1'b1;
				sel_q     <= cmp_addr_q;
				wb_need_q <= 1'b0;
				wb_page_q <= '0;
				wb_cnt_q  <= '0;
				load_q    <= '0;
			end else begin
				hit_w_q <= 1'b0;
			end
		end
		if (state_q == ST_WB) begin
			sel_q     <= vp_q;
			wb_need_q <= valid_q[vp_q] && dirty_q[vp_q];
			wb_page_q <= (valid_q[vp_q] && dirty_q[vp_q]) ? rdata : '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
			load_q <= fpcc_pkg::page_len(load_start, ps_q, total_q);
		end
		if (state_q == ST_LEN) begin
			wb_cnt_q <= wb_need_q ? fpcc_pkg::page_len(prod_q, ps_q, total_q) : '0;
		end
		if (emit) begin
			o_hit_q     <= hit_w_q;
			o_slot_q    <= 6'(sel_q);
			o_off_q     <= off_q;
			o_page_q    <= page_q;
			o_wb_need_q <= wb_need_q;
			o_wb_page_q <= wb_page_q;
			o_wb_cnt_q  <= wb_cnt_q;
			o_load_q    <= load_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = o_hit_q;
	assign slot             = o_slot_q;
	assign offset           = o_off_q;
	assign page_number      = o_page_q;
	assign writeback_needed = o_wb_need_q;
	assign writeback_page   = o_wb_page_q;
	assign writeback_count  = o_wb_cnt_q;
	assign load_count       = o_load_q;
	assign fault_count      = faults_q;
	assign hit_count        = hits_q;

endmodule
